/* rtl/core/double_ended_queue_unit_assert.svh */
// Assertion macros for the double-ended queue unit.
// Needs a clock and an active-high reset at the place of use.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEQU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dequ_pkg.sv */
// Shared types and codes for the double-ended queue unit.
// No dependencies.
package dequ_pkg;

  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Pointer updates requested by the sequencer.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } ptr_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ptr_flags_t;

endpackage

/* rtl/core/dequ_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dequ_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/dequ_ptr.sv */
// Front pointer and entry count of the ring store, with the slot addresses
// derived from them. Depends on dequ_pkg.
module dequ_ptr #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dequ_pkg::ptr_cmd_t         cmd,
  input  logic [$clog2(DEPTH+1)-1:0] list_off,
  output dequ_pkg::ptr_flags_t       flags,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [$clog2(DEPTH)-1:0]   front_addr,
  output logic [$clog2(DEPTH)-1:0]   push_front_addr,
  output logic [$clog2(DEPTH)-1:0]   push_back_addr,
  output logic [$clog2(DEPTH)-1:0]   pop_back_addr,
  output logic [$clog2(DEPTH)-1:0]   list_addr
);

  import dequ_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] TOP_A   = AW'(DEPTH - 1);

  logic [AW-1:0] front;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count_next;

  // Offsets never exceed DEPTH, so one conditional subtract wraps the sum.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  assign flags.empty     = (count == '0);
  assign flags.full      = (count == DEPTH_C);
  assign front_addr      = front;
  assign push_front_addr = (front == '0) ? TOP_A : front - AW'(1);
  assign push_back_addr  = slot(front, count);
  assign pop_back_addr   = slot(front, count - CW'(1));
  assign list_addr       = slot(front, list_off);

  always_comb begin
    front_next = front;
    count_next = count;
    if (cmd.push_front) begin
      front_next = push_front_addr;
      count_next = count + CW'(1);
    end else if (cmd.push_back) begin
      count_next = count + CW'(1);
    end else if (cmd.pop_front) begin
      front_next = (front == TOP_A) ? '0 : front + AW'(1);
      count_next = count - CW'(1);
    end else if (cmd.pop_back) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule

/* rtl/core/double_ended_queue_unit.sv */
// Channel   Handshake             Payload
// request   in_valid / in_stall   op, value
// result    out_valid / out_stall data, status, last
//
// Pushes and empty or full answers load the result register as the request is taken.
// Pops first read the store, then load the result once the output register is free.
// A list reads its entries in order through the single read port, one result each.
// Reset is synchronous and empties the queue; the store itself is not cleared.
// A stalled result holds its register; the next request waits behind it.
module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dequ_pkg::OP_W-1:0]           op,
  input  logic signed [dequ_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dequ_pkg::DATA_W-1:0]  data,
  output logic [dequ_pkg::STATUS_W-1:0]       status,
  output logic                                last
);

  import dequ_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_t;

  state_t            state;
  logic [CW-1:0]     list_idx;
  logic [CW-1:0]     list_off;
  logic              list_last;
  logic              out_free;
  logic              out_load;
  logic              in_accept;
  logic              is_push;
  ptr_cmd_t          cmd;
  ptr_flags_t        flags;
  logic [CW-1:0]     count;
  logic [AW-1:0]     front_addr;
  logic [AW-1:0]     push_front_addr;
  logic [AW-1:0]     push_back_addr;
  logic [AW-1:0]     pop_back_addr;
  logic [AW-1:0]     list_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;
  assign is_push   = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
  assign list_off  = list_idx + CW'(1);
  assign list_last = (list_off == count);

  // A new result enters the output register in this cycle.
  assign out_load = (in_accept && (is_push || (flags.empty &&
                     ((op == OP_POP_FRONT) || (op == OP_POP_BACK) || (op == OP_LIST))))) ||
                    (((state == S_POP) || (state == S_LIST)) && out_free);

  always_comb begin
    cmd.push_front = in_accept && (op == OP_PUSH_FRONT) && !flags.full;
    cmd.push_back  = in_accept && (op == OP_PUSH_BACK) && !flags.full;
    cmd.pop_front  = in_accept && (op == OP_POP_FRONT) && !flags.empty;
    cmd.pop_back   = in_accept && (op == OP_POP_BACK) && !flags.empty;
  end

  assign ram_we    = cmd.push_front || cmd.push_back;
  assign ram_waddr = cmd.push_front ? push_front_addr : push_back_addr;

  // The pop address is taken before the pointer moves at the same edge.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = front_addr;
    if (cmd.pop_front) begin
      ram_re = 1'b1;
    end else if (cmd.pop_back) begin
      ram_re    = 1'b1;
      ram_raddr = pop_back_addr;
    end else if (in_accept && (op == OP_LIST) && !flags.empty) begin
      ram_re = 1'b1;
    end else if ((state == S_LIST) && out_free && !list_last) begin
      ram_re    = 1'b1;
      ram_raddr = list_addr;
    end
  end

  dequ_ptr #(
    .DEPTH(DEPTH)
  ) u_ptr (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .list_off        (list_off),
    .flags           (flags),
    .count           (count),
    .front_addr      (front_addr),
    .push_front_addr (push_front_addr),
    .push_back_addr  (push_back_addr),
    .pop_back_addr   (pop_back_addr),
    .list_addr       (list_addr)
  );

  dequ_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      list_idx  <= '0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (is_push) begin
              out_valid <= 1'b1;
              data      <= '0;
              status    <= flags.full ? ST_FULL : ST_OK;
              last      <= 1'b1;
            end else if ((op == OP_POP_FRONT) || (op == OP_POP_BACK) ||
                         (op == OP_LIST)) begin
              if (flags.empty) begin
                out_valid <= 1'b1;
                data      <= '0;
                status    <= ST_EMPTY;
                last      <= 1'b1;
              end else if (op == OP_LIST) begin
                list_idx <= '0;
                state    <= S_LIST;
              end else begin
                state <= S_POP;
              end
            end
          end
        end
        S_POP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            data      <= $signed(ram_rdata);
            status    <= ST_OK;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_LIST: begin
          if (out_free) begin
            out_valid <= 1'b1;
            data      <= $signed(ram_rdata);
            status    <= ST_OK;
            last      <= list_last;
            if (list_last) begin
              state <= S_IDLE;
            end else begin
              list_idx <= list_off;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "double_ended_queue_unit_assert.svh"

  `DEQU_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH),
                    "entry count above depth")
  `DEQU_ASSERT_NEXT(a_full_push_kept, clk, rst, in_accept && is_push && flags.full,
                    $stable(count), "full push changed the count")
  `DEQU_ASSERT_SAME(a_list_nonempty, clk, rst, state == S_LIST,
                    !flags.empty && (list_idx < count), "list walk outside live entries")
  `DEQU_ASSERT_SAME(a_busy_stalls, clk, rst, state != S_IDLE, in_stall,
                    "request taken while busy")

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue_unit: a scoreboard class predicts every result.
// Depends on dequ_pkg and the RTL of double_ended_queue_unit only.
module tb;
  import dequ_pkg::*;

  localparam int QDEPTH   = 16;
  localparam int ITEMS    = 350;
  localparam int WATCHDOG = 1000;
  localparam int DRAIN    = 40;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } result_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  class deque_scoreboard;
    logic signed [DATA_W-1:0] ring [QDEPTH];
    int head;
    int fill;
    int deepest;
    result_t pending [$];
    int errors;
    int checked;
    int full_hits;
    int empty_hits;

    function new();
      head = 0;
      fill = 0;
      deepest = 0;
      errors = 0;
      checked = 0;
      full_hits = 0;
      empty_hits = 0;
    endfunction

    function void queue_result(logic signed [DATA_W-1:0] d, logic [STATUS_W-1:0] s,
                               logic l);
      result_t r;
      r.data = d;
      r.status = s;
      r.last = l;
      pending.push_back(r);
    endfunction

    // Updates the predicted deque for one accepted request and queues its results.
    function void note_request(logic [OP_W-1:0] code, logic signed [DATA_W-1:0] v);
      int k;
      case (code)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill >= QDEPTH) begin
            queue_result('0, ST_FULL, 1'b1);
            full_hits++;
          end else begin
            if (code == OP_PUSH_FRONT) begin
              head = (head + QDEPTH - 1) % QDEPTH;
              ring[head] = v;
            end else begin
              ring[(head + fill) % QDEPTH] = v;
            end
            fill++;
            if (fill > deepest) deepest = fill;
            queue_result('0, ST_OK, 1'b1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_LIST: begin
          if (fill == 0) begin
            queue_result('0, ST_EMPTY, 1'b1);
            empty_hits++;
          end else if (code == OP_POP_FRONT) begin
            queue_result(ring[head], ST_OK, 1'b1);
            head = (head + 1) % QDEPTH;
            fill--;
          end else if (code == OP_POP_BACK) begin
            queue_result(ring[(head + fill - 1) % QDEPTH], ST_OK, 1'b1);
            fill--;
          end else begin
            for (k = 0; k < fill; k++)
              queue_result(ring[(head + k) % QDEPTH], ST_OK, k == fill - 1);
          end
        end
        default: ;  // unused codes are dropped without a result
      endcase
    endfunction

    function void check_result(logic signed [DATA_W-1:0] d, logic [STATUS_W-1:0] s,
                               logic l);
      result_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result data %0d status %0d last %0d", $time, d, s, l);
        errors++;
      end else begin
        want = pending.pop_front();
        if (d !== want.data) begin
          $display("%0t: data expected %0d actual %0d", $time, want.data, d);
          errors++;
        end
        if (s !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, s);
          errors++;
        end
        if (l !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, l);
          errors++;
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          op = OP_PUSH_FRONT;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] data;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  deque_scoreboard sb = new();
  bit steady = 1'b0;
  int quiet = 0;
  int op_seen [8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  double_ended_queue_unit #(.DEPTH(QDEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .data     (data),
    .status   (status),
    .last     (last)
  );

  // Result side: check what was accepted at this edge, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(data, status, last);
    out_stall <= !steady && ($urandom_range(0, 99) < 21);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG);
      $display("double_ended_queue_unit test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_request(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] v);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_request(code, v);
    op_seen[code]++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(mix_t mix);
    int r;
    int push_share;
    r = $urandom_range(0, 99);
    push_share = (mix == MIX_FILL) ? 68 : (mix == MIX_DRAIN) ? 28 : 54;
    if (r < 8) return OP_LIST;
    if (r < push_share) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  initial begin
    int sent;
    int len;
    int k;
    mix_t mix;
    bit steady_done;
    bit paused;
    sent = 0;
    steady_done = 1'b0;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty answers, extreme values, unused codes, then fill past full.
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_LIST, '0);
    send_request(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_request(OP_PUSH_BACK, 32'h8000_0000);
    send_request(OP_PUSH_FRONT, '0);
    send_request(OP_PUSH_BACK, '1);
    send_request(OP_LIST, '0);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);
    send_request(3'd5, 32'h1234_5678);
    send_request(3'd6, '1);
    send_request(3'd7, '0);
    for (k = 0; k < QDEPTH - 2; k++)
      send_request(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom);
    send_request(OP_PUSH_BACK, 32'h5a5a_a5a5);
    send_request(OP_LIST, '0);

    while (sent < ITEMS) begin
      mix = mix_t'($urandom_range(0, 2));
      len = $urandom_range(8, 30);
      if (!steady_done && sent >= 120) begin
        steady = 1'b1;
        len = 60;
      end
      if (!paused && sent >= 240) begin
        // Let the block drain completely before the next request.
        paused = 1'b1;
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 3) begin
          send_request(OP_W'($urandom_range(5, 7)), $urandom);
        end else begin
          send_request(pick_op(mix), pick_value());
          sent++;
        end
      end
      if (steady) begin
        steady = 1'b0;
        steady_done = 1'b1;
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Requests: %0d push front, %0d push back, %0d pop front, %0d pop back, %0d list,",
             op_seen[OP_PUSH_FRONT], op_seen[OP_PUSH_BACK], op_seen[OP_POP_FRONT],
             op_seen[OP_POP_BACK], op_seen[OP_LIST]);
    $display("%0d unused codes; %0d results checked, %0d full, %0d empty, deepest fill %0d.",
             op_seen[5] + op_seen[6] + op_seen[7], sb.checked, sb.full_hits,
             sb.empty_hits, sb.deepest);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("double_ended_queue_unit test passed");
    end else begin
      $display("double_ended_queue_unit test failed");
    end
    $finish;
  end
endmodule
